FILE: rtl/nptx_pkg.sv
// Shared types, constants and helpers of the pulse-width serial transmitter.
// Depends on nothing; every other file but nptx_ram imports it.
package nptx_pkg;

	localparam int FIFO_DEPTH_DEF = 16;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	localparam logic [7:0]  CHANNEL_RESET = 8'hFF;
	localparam logic [11:0] PULSE_BASE_US = 12'd1024;
	localparam int          PULSE_SHIFT   = 6;      // 64 us per nibble step
	localparam logic [4:0]  IDLE_NIBBLE   = 5'd16;
	localparam logic [11:0] IDLE_WIDTH_US = 12'd2048;

	// Request from the pulse sequencer to the ring for one processed item.
	typedef struct packed {
		logic       step;
		logic       push;
		logic       pop;
		logic       flush;
		logic [7:0] wdata;
	} ring_req_t;

	// Ring status: current head and flags, plus the post-step empty flag.
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       push_ok;
		logic       empty_nx;
		logic [7:0] head;
	} ring_stat_t;

	function automatic logic [11:0] pulse_width(input logic [4:0] nib);
		pulse_width = PULSE_BASE_US + (12'(nib) << PULSE_SHIFT);
	endfunction

endpackage

FILE: rtl/nptx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on no package.
module nptx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/nptx_ring.sv
// Byte ring of the transmitter: pointers, head prefetch and write bypass.
// Depends on nptx_pkg and nptx_ram.
module nptx_ring
	import nptx_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_req_t  req,
	output ring_stat_t stat
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [PTR_W-1:0] rd_q, wr_q, rd_nx, wr_nx, rd_inc, wr_inc;
	logic             byp_q;
	logic [7:0]       byp_data_q;
	logic [7:0]       ram_rdata;
	logic             push_ok;

	assign rd_inc = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
	assign wr_inc = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;

	assign push_ok = req.push && (wr_inc != rd_q);

	always_comb begin
		rd_nx = rd_q;
		wr_nx = wr_q;
		if (req.flush) begin
			rd_nx = '0;
			wr_nx = '0;
		end else begin
			if (req.pop) begin
				rd_nx = rd_inc;
			end
			if (push_ok) begin
				wr_nx = wr_inc;
			end
		end
	end

	// Prefetch the new head; a write into the slot being read is bypassed.
	nptx_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.step && push_ok),
		.waddr (wr_q),
		.wdata (req.wdata),
		.re    (req.step),
		.raddr (rd_nx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			byp_q <= 1'b0;
		end else if (req.step) begin
			rd_q  <= rd_nx;
			wr_q  <= wr_nx;
			byp_q <= push_ok && (wr_q == rd_nx);
		end
	end

	always_ff @(posedge clk) begin
		if (req.step) begin
			byp_data_q <= req.wdata;
		end
	end

	assign stat.empty    = (rd_q == wr_q);
	assign stat.full     = (wr_inc == rd_q);
	assign stat.push_ok  = push_ok;
	assign stat.empty_nx = (rd_nx == wr_nx);
	assign stat.head     = byp_q ? byp_data_q : ram_rdata;

endmodule

FILE: rtl/nibble_pulse_width_serial_tx.sv
// Top level of the nibble pulse-width serial transmitter: input register,
// pulse sequencer, result register. Depends on nptx_pkg and nptx_ring.
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------
//   in        in_valid / in_ready     mode, data_byte
//   out       out_valid / out_ready   write_accepted, pulse_valid,
//                                     pulse_len_us, pulse_channel,
//                                     head_byte, fifo_empty
//   cfg       cfg_valid / cfg_ready   cfg_data (channel_number)
//
// One beat per cycle sustained while out_ready stays high; an item's result
// is registered: the input register takes the beat, and the result register
// and the RAM read register load when the item advances.
// Each step is set by the ring update and the head prefetch read
// of the byte RAM, addressed by the next read pointer.
// Reset: no clearing pass; pointers, pending flag and channel (255) reset at once.
// Stalls: with the result held, one more beat is taken into the input register,
// then in_ready drops until out_ready returns. cfg_ready is always high.
module nibble_pulse_width_serial_tx
	import nptx_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_accepted,
	output logic        pulse_valid,
	output logic [11:0] pulse_len_us,
	output logic [7:0]  pulse_channel,
	output logic [7:0]  head_byte,
	output logic        fifo_empty,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	// Input register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] data_s1;

	// Sequencer state and configuration
	logic       pending_q;
	logic [7:0] cur_q;
	logic [7:0] channel_q;

	// Result register
	logic        out_valid_q;
	logic        wacc_q;
	logic        pvalid_q;
	logic [11:0] width_q;
	logic [7:0]  chan_q;
	logic        empty_q;

	logic       adv;
	logic       is_tick;
	logic [4:0] nib;
	ring_req_t  ring_req;
	ring_stat_t ring_st;

	// Advance when an item waits and the result slot is free or being drained.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign is_tick  = (mode_s1 == MODE_TICK);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RESET;
		end else if (cfg_valid) begin
			channel_q <= cfg_data;
		end
	end

	// Capture a beat into the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			data_s1 <= data_byte;
		end
	end

	// Ring request: pop only when no low nibble is owed and a byte is there.
	always_comb begin
		ring_req.step  = adv;
		ring_req.push  = (mode_s1 == MODE_WRITE);
		ring_req.pop   = is_tick && !pending_q && !ring_st.empty;
		ring_req.flush = (mode_s1 == MODE_FLUSH);
		ring_req.wdata = data_s1;
	end

	nptx_ring #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ring_req),
		.stat   (ring_st)
	);

	// Pick the nibble: owed low nibble, fresh high nibble, or idle.
	always_comb begin
		if (pending_q) begin
			nib = {1'b0, cur_q[3:0]};
		end else if (!ring_st.empty) begin
			nib = {1'b0, ring_st.head[7:4]};
		end else begin
			nib = IDLE_NIBBLE;
		end
	end

	// Advance the half-sent byte tracker on ticks only; flush leaves it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			cur_q     <= '0;
		end else if (adv && is_tick) begin
			if (pending_q) begin
				pending_q <= 1'b0;
			end else if (!ring_st.empty) begin
				pending_q <= 1'b1;
				cur_q     <= ring_st.head;
			end
		end
	end

	// Result register; hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wacc_q   <= ring_req.push && ring_st.push_ok;
			pvalid_q <= is_tick;
			width_q  <= is_tick ? pulse_width(nib) : '0;
			chan_q   <= is_tick ? channel_q : '0;
			empty_q  <= ring_st.empty_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_accepted = wacc_q;
	assign pulse_valid    = pvalid_q;
	assign pulse_len_us   = width_q;
	assign pulse_channel  = chan_q;
	// Head comes from the prefetch register, which holds with the result.
	assign head_byte      = empty_q ? 8'h00 : ring_st.head;
	assign fifo_empty     = empty_q;

	// A high nibble sent from a nonempty ring must leave the low nibble owed.
	a_pending_set: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_tick && !pending_q && !ring_st.empty |=> pending_q)
		else $error("low nibble not marked pending after high nibble");

	// An idle width in the result means no byte is half sent.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pvalid_q && (width_q == IDLE_WIDTH_US) |-> !pending_q)
		else $error("idle pulse while a low nibble is owed");

	// A flush always reports an empty ring.
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (mode_s1 == MODE_FLUSH) |=> fifo_empty && out_valid)
		else $error("ring not empty after flush");

	// Input side stalls only when the result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without output back-pressure");

endmodule

FILE: bench/nptx_pulse_checker.sv
// Scoreboard for the pulse-width serial transmitter. It watches the input,
// result and register channels, keeps its own ring model and compares results.
// Needs nptx_pkg.
module nptx_pulse_checker
	import nptx_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        write_accepted,
	input  logic        pulse_valid,
	input  logic [11:0] pulse_len_us,
	input  logic [7:0]  pulse_channel,
	input  logic [7:0]  head_byte,
	input  logic        fifo_empty,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          mismatch_total,
	output int          reports_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        accepted;
		logic        pulse;
		logic [11:0] width_us;
		logic [7:0]  channel;
		logic [7:0]  head;
		logic        empty;
	} step_report_t;

	localparam int PW = $clog2(DEPTH);

	logic [7:0]   slots [DEPTH];
	int unsigned  rd_ptr = 0;
	int unsigned  wr_ptr = 0;
	logic         low_half_owed = 1'b0;
	logic [7:0]   held_byte = 8'h00;
	logic [7:0]   channel_reg = CHANNEL_RESET;
	step_report_t awaited_reports [$];
	int           failures = 0;

	function automatic logic [11:0] nibble_to_us(input logic [3:0] nib);
		return PULSE_BASE_US + {2'b00, nib, 6'b000000};
	endfunction

	// Apply one item to the ring model and return the result it should produce.
	function automatic step_report_t advance_ring(input logic [1:0] op,
			input logic [7:0] value);
		step_report_t r;
		int unsigned  nxt;
		r = '0;
		nxt = (wr_ptr + 1) % DEPTH;
		case (op)
			MODE_WRITE: begin
				if (nxt != rd_ptr) begin
					slots[PW'(wr_ptr)] = value;
					wr_ptr = nxt;
					r.accepted = 1'b1;
				end
			end
			MODE_TICK: begin
				r.pulse = 1'b1;
				r.channel = channel_reg;
				if (low_half_owed) begin
					r.width_us = nibble_to_us(held_byte[3:0]);
					low_half_owed = 1'b0;
				end else if (rd_ptr != wr_ptr) begin
					held_byte = slots[PW'(rd_ptr)];
					rd_ptr = (rd_ptr + 1) % DEPTH;
					r.width_us = nibble_to_us(held_byte[7:4]);
					low_half_owed = 1'b1;
				end else
					r.width_us = IDLE_WIDTH_US;
			end
			MODE_FLUSH: begin
				rd_ptr = 0;
				wr_ptr = 0;
			end
			default: ;
		endcase
		r.empty = (rd_ptr == wr_ptr);
		r.head = r.empty ? 8'h00 : slots[PW'(rd_ptr)];
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		step_report_t want;
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			low_half_owed = 1'b0;
			held_byte = 8'h00;
			channel_reg = CHANNEL_RESET;
			awaited_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				channel_reg = cfg_data;
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					$error("result beat arrived with no item outstanding");
					failures++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("write_accepted", 32'(want.accepted),
						32'(write_accepted));
					check_field("pulse_valid", 32'(want.pulse), 32'(pulse_valid));
					check_field("pulse_len_us", 32'(want.width_us),
						32'(pulse_len_us));
					check_field("pulse_channel", 32'(want.channel),
						32'(pulse_channel));
					check_field("head_byte", 32'(want.head), 32'(head_byte));
					check_field("fifo_empty", 32'(want.empty), 32'(fifo_empty));
				end
			end
			if (in_valid && in_ready)
				awaited_reports.push_back(advance_ring(mode, data_byte));
		end
		mismatch_total <= failures;
		reports_owed <= awaited_reports.size();
	end

endmodule

FILE: bench/tb_nibble_pulse_width_serial_tx.sv
// Top of the transmitter testbench: clock, reset, directed and random beats,
// receiver back-pressure and the final verdict. Needs nptx_pkg,
// nptx_pulse_checker and the block itself.
module tb_nibble_pulse_width_serial_tx;
	timeunit 1ns;
	timeprecision 1ps;
	import nptx_pkg::*;

	// Mode 3 has no function in the block; it must leave the ring untouched.
	localparam logic [1:0] MODE_SPARE    = 2'd3;
	localparam int         RANDOM_PHASES = 10;
	localparam int         PHASE_ITEMS   = 52;
	// Margin beyond the block's latency, for the pipe to go quiet.
	localparam int         SETTLE_CYCLES = 4;
	// Slowest run: ~540 beats, each with an idle gap, a stall and the latency,
	// plus the drains between phases. This is many times that.
	localparam int         CYCLE_LIMIT   = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_WRITE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        write_accepted;
	logic        pulse_valid;
	logic [11:0] pulse_len_us;
	logic [7:0]  pulse_channel;
	logic [7:0]  head_byte;
	logic        fifo_empty;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	int          mismatch_total;
	int          reports_owed;
	int unsigned cycle_count = 0;
	int          stall_left = 0;
	// When set, neither side idles: back-to-back beats at full rate.
	bit          calm = 1'b0;

	int          write_share [RANDOM_PHASES] = '{85, 30, 60, 50, 90, 20, 55, 70, 40, 50};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	nibble_pulse_width_serial_tx uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_accepted (write_accepted),
		.pulse_valid    (pulse_valid),
		.pulse_len_us   (pulse_len_us),
		.pulse_channel  (pulse_channel),
		.head_byte      (head_byte),
		.fifo_empty     (fifo_empty),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	nptx_pulse_checker pulse_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_accepted (write_accepted),
		.pulse_valid    (pulse_valid),
		.pulse_len_us   (pulse_len_us),
		.pulse_channel  (pulse_channel),
		.head_byte      (head_byte),
		.fifo_empty     (fifo_empty),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_total (mismatch_total),
		.reports_owed   (reports_owed)
	);

	// Receiver: after each result beat, draw a random stall length and hold
	// out_ready low for that long, then raise it until the next beat.
	always @(posedge clk) begin : sink
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (out_valid && out_ready) begin
			stall = calm ? 0 : $urandom_range(0, 7);
			out_ready <= (stall == 0);
			stall_left <= (stall == 0) ? 0 : stall - 1;
		end else
			out_ready <= 1'b1;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[nibble_pulse_width_serial_tx] ERROR");
			$finish;
		end
	end

	// Idle a random gap (none when calm), then present one beat and hold it until accepted.
	// With no idle gap, in_valid stays high and only the payload moves.
	task automatic send_beat(input logic [1:0] op, input logic [7:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= op;
		data_byte <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every result is back and the pipe is quiet.
	// The owed count is registered, so look at it only after the next edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_channel(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int          roll;
		logic [7:0]  chan;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, channel still at its reset value.
		// Empty ring: tick gives the idle width, spare mode and flush are no-ops.
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_SPARE, 8'hFF);
		send_beat(MODE_FLUSH, 8'h00);
		// Extremes and alternating bit patterns of the data byte.
		send_beat(MODE_WRITE, 8'h00);
		send_beat(MODE_WRITE, 8'hFF);
		send_beat(MODE_WRITE, 8'hA5);
		send_beat(MODE_WRITE, 8'h5A);
		// Nibble 0 twice, then the high nibble F of the next byte.
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_TICK, 8'h00);
		// Flush with a byte half sent: its low nibble still goes out, then idle.
		send_beat(MODE_FLUSH, 8'h00);
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_TICK, 8'h00);
		// Spare mode with bytes waiting: head stays, nothing consumed.
		send_beat(MODE_WRITE, 8'h3C);
		send_beat(MODE_SPARE, 8'h00);
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_TICK, 8'h00);

		// Random phases, each behind a full drain and a channel write.
		// Write-heavy phases fill the ring into its full case, tick-heavy ones
		// drain it into idle pulses; some flushes and spare modes sprinkled in.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0:       chan = 8'h00;
				1:       chan = 8'hFF;
				default: chan = 8'($urandom_range(0, 255));
			endcase
			set_channel(chan);
			calm = (phase % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					send_beat(MODE_SPARE, 8'($urandom_range(0, 255)));
				else if (roll < 6)
					send_beat(MODE_FLUSH, 8'($urandom_range(0, 255)));
				else if (roll < 6 + write_share[phase] * 94 / 100)
					send_beat(MODE_WRITE, 8'($urandom_range(0, 255)));
				else
					send_beat(MODE_TICK, 8'($urandom_range(0, 255)));
			end
		end

		drain_results();
		if (mismatch_total == 0)
			$display("[nibble_pulse_width_serial_tx] OK");
		else
			$display("[nibble_pulse_width_serial_tx] ERROR");
		$finish;
	end

endmodule
